// File: sv/snowv_pkg.sv
// ----------------------------------------------------------------------------
// snowv_pkg
// shared types, constants and round functions of the snow-v keystream block
// ----------------------------------------------------------------------------
package snowv_pkg;

   localparam int NumRegs = 6;
   localparam int AddrWidth = 6;
   localparam int InitRounds = 16;
   localparam int RoundWidth = 4;

   typedef enum logic [2:0] {
      REG_KEY0 = 3'd0,
      REG_KEY1 = 3'd1,
      REG_KEY2 = 3'd2,
      REG_KEY3 = 3'd3,
      REG_IV0  = 3'd4,
      REG_IV1  = 3'd5
   } reg_index_type;

   typedef enum logic [0:0] {
      KIND_INIT = 1'b0,
      KIND_DATA = 1'b1
   } kind_type;

   // controller to datapath
   typedef struct packed {
      logic load;       // load lfsrs from key and iv, clear fsm
      logic step;       // advance cipher one word
      logic fold;       // init round: fold keystream into lfsr a
      logic key_lo;     // xor key low half into r1
      logic key_hi;     // xor key high half into r1
      logic capture;    // register output word
   } dp_cmd_type;

   typedef logic [15:0] cell_type;

   localparam logic [7:0] SBOX [256] = '{
      8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
      8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
      8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
      8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
      8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
      8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
      8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
      8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
      8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
      8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
      8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
      8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
      8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
      8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
      8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
      8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16};

   function automatic logic [127:0] aes_round(input logic [127:0] src);
      logic [7:0]   sb [16];
      logic [31:0]  col;
      logic [31:0]  mix;
      logic [127:0] res;
      for (int b = 0; b < 16; b++) begin
         sb[b] = SBOX[src[8*b +: 8]];
      end
      for (int p = 0; p < 4; p++) begin
         col = {sb[4*p], sb[(4*p+15) & 15], sb[(4*p+10) & 15], sb[(4*p+5) & 15]};
         mix = {col[15:0], col[31:16]} ^ ((col << 1) & 32'hfefefefe)
               ^ (((col >> 7) & 32'h01010101) * 32'h1b);
         res[32*p +: 32] = col ^ mix ^ {mix[23:0], mix[31:24]};
      end
      return res;
   endfunction

   function automatic cell_type times_x(input cell_type a, input cell_type poly);
      return a[15] ? ({a[14:0], 1'b0} ^ poly) : {a[14:0], 1'b0};
   endfunction

   function automatic cell_type times_xinv(input cell_type a, input cell_type poly);
      return a[0] ? ({1'b0, a[15:1]} ^ poly) : {1'b0, a[15:1]};
   endfunction

endpackage

// File: sv/snowv_datapath.sv
// ----------------------------------------------------------------------------
// snowv_datapath
// lfsr, fsm and keystream logic; one cipher step per cycle on command
// ----------------------------------------------------------------------------
module snowv_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  snowv_pkg::dp_cmd_type cmd,
   input  logic [255:0]          key,
   input  logic [127:0]          iv,
   input  logic [127:0]          data,
   output logic [127:0]          text
);

   snowv_pkg::cell_type lfsr_a_ff [16];
   snowv_pkg::cell_type lfsr_a_in [16];
   snowv_pkg::cell_type lfsr_b_ff [16];
   snowv_pkg::cell_type lfsr_b_in [16];
   logic [127:0] r1_ff, r1_in, r2_ff, r2_in, r3_ff, r3_in;
   logic [127:0] text_ff, text_in;
   logic [127:0] ks;
   logic [127:0] t1, t2;
   snowv_pkg::cell_type sa [24];
   snowv_pkg::cell_type sb [24];

   always_comb begin
      for (int n = 0; n < 4; n++) begin
         ks[32*n +: 32] = ({lfsr_b_ff[2*n+9], lfsr_b_ff[2*n+8]} + r1_ff[32*n +: 32])
                          ^ r2_ff[32*n +: 32];
         t1[32*n +: 32] = ({lfsr_a_ff[2*n+1], lfsr_a_ff[2*n]} ^ r3_ff[32*n +: 32])
                          + r2_ff[32*n +: 32];
      end
      for (int m = 0; m < 16; m++) begin
         sa[m] = lfsr_a_ff[m];
         sb[m] = lfsr_b_ff[m];
      end
      for (int s = 0; s < 8; s++) begin
         sa[s+16] = snowv_pkg::times_x(sa[s], 16'h990f) ^ sa[s+1]
                    ^ snowv_pkg::times_xinv(sa[s+8], 16'hcc87) ^ sb[s];
         sb[s+16] = snowv_pkg::times_x(sb[s], 16'hc963) ^ sb[s+3]
                    ^ snowv_pkg::times_xinv(sb[s+8], 16'he4b1) ^ sa[s];
      end
      t2 = t1;
      if (cmd.key_lo) t2 = t2 ^ key[127:0];
      if (cmd.key_hi) t2 = t2 ^ key[255:128];
      for (int m = 0; m < 16; m++) begin
         lfsr_a_in[m] = lfsr_a_ff[m];
         lfsr_b_in[m] = lfsr_b_ff[m];
      end
      r1_in = r1_ff;
      r2_in = r2_ff;
      r3_in = r3_ff;
      text_in = text_ff;
      if (cmd.load) begin
         for (int m = 0; m < 8; m++) begin
            lfsr_a_in[m]   = iv[16*m +: 16];
            lfsr_a_in[m+8] = key[16*m +: 16];
            lfsr_b_in[m]   = '0;
            lfsr_b_in[m+8] = key[128 + 16*m +: 16];
         end
         r1_in = '0;
         r2_in = '0;
         r3_in = '0;
      end else if (cmd.step) begin
         for (int m = 0; m < 16; m++) begin
            lfsr_a_in[m] = sa[m+8];
            lfsr_b_in[m] = sb[m+8];
         end
         if (cmd.fold) begin
            for (int m = 0; m < 8; m++) begin
               lfsr_a_in[m+8] = sa[m+16] ^ ks[16*m +: 16];
            end
         end
         r1_in = t2;
         r2_in = snowv_pkg::aes_round(r1_ff);
         r3_in = snowv_pkg::aes_round(r2_ff);
      end
      if (cmd.capture) text_in = data ^ ks;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int m = 0; m < 16; m++) begin
            lfsr_a_ff[m] <= '0;
            lfsr_b_ff[m] <= '0;
         end
         r1_ff   <= '0;
         r2_ff   <= '0;
         r3_ff   <= '0;
         text_ff <= '0;
      end else begin
         for (int m = 0; m < 16; m++) begin
            lfsr_a_ff[m] <= lfsr_a_in[m];
            lfsr_b_ff[m] <= lfsr_b_in[m];
         end
         r1_ff   <= r1_in;
         r2_ff   <= r2_in;
         r3_ff   <= r3_in;
         text_ff <= text_in;
      end
   end

   assign text = text_ff;

endmodule

// File: sv/snowv_control.sv
// ----------------------------------------------------------------------------
// snowv_control
// handshake and sequencing of init rounds and data words
// ----------------------------------------------------------------------------
module snowv_control (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_kind,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output snowv_pkg::dp_cmd_type cmd
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_INIT = 3'b010,
      ST_OUT  = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic [snowv_pkg::RoundWidth-1:0] round_ff, round_in;
   logic accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);
   assign accept = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      round_in = round_ff;
      cmd = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_kind == snowv_pkg::KIND_INIT) begin
                  cmd.load = 1'b1;
                  round_in = '0;
                  state_in = ST_INIT;
               end else begin
                  cmd.step = 1'b1;
                  cmd.capture = 1'b1;
                  state_in = ST_OUT;
               end
            end
         end
         ST_INIT: begin
            cmd.step = 1'b1;
            cmd.fold = 1'b1;
            cmd.key_lo = (round_ff == snowv_pkg::RoundWidth'(14));
            cmd.key_hi = (round_ff == snowv_pkg::RoundWidth'(15));
            round_in = round_ff + 1'b1;
            if (round_ff == snowv_pkg::RoundWidth'(snowv_pkg::InitRounds - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_OUT: begin
            if (rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         round_ff <= '0;
      end else begin
         state_ff <= state_in;
         round_ff <= round_in;
      end
   end

endmodule

// File: sv/snow_v_keystream_cipher.sv
// ----------------------------------------------------------------------------
// snow_v_keystream_cipher
// snow-v stream cipher, 256-bit key and 128-bit iv in csr registers
// ----------------------------------------------------------------------------
// An init word (kind 0) loads the cipher from the key and iv registers and
// runs 16 warm-up rounds, one per cycle, and gives no result. A data word
// (kind 1) is xored with one 128-bit keystream word and the cipher advances
// one step in the accept cycle; the result is presented the next cycle and a
// new word is taken once it is delivered.
// Registers are 64 bits at byte address 8*i; writes take effect at init.
module snow_v_keystream_cipher (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_kind,
   input  logic [63:0]                     req_data_low,
   input  logic [63:0]                     req_data_high,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [63:0]                     rsp_text_low,
   output logic [63:0]                     rsp_text_high,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [snowv_pkg::AddrWidth-1:0] paddr,
   input  logic [63:0]                     pwdata,
   output logic [63:0]                     prdata,
   output logic                            pready
);

   logic [63:0] regs_ff [snowv_pkg::NumRegs];
   logic [2:0] idx;
   snowv_pkg::dp_cmd_type cmd;
   logic [127:0] text;

   assign pready = 1'b1;
   assign idx = paddr[5:3];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < snowv_pkg::NumRegs; i++) regs_ff[i] <= '0;
      end else if (psel && penable && pwrite && paddr[2:0] == 3'd0) begin
         unique case (idx)
            snowv_pkg::REG_KEY0: regs_ff[0] <= pwdata;
            snowv_pkg::REG_KEY1: regs_ff[1] <= pwdata;
            snowv_pkg::REG_KEY2: regs_ff[2] <= pwdata;
            snowv_pkg::REG_KEY3: regs_ff[3] <= pwdata;
            snowv_pkg::REG_IV0:  regs_ff[4] <= pwdata;
            snowv_pkg::REG_IV1:  regs_ff[5] <= pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         snowv_pkg::REG_KEY0: prdata = regs_ff[0];
         snowv_pkg::REG_KEY1: prdata = regs_ff[1];
         snowv_pkg::REG_KEY2: prdata = regs_ff[2];
         snowv_pkg::REG_KEY3: prdata = regs_ff[3];
         snowv_pkg::REG_IV0:  prdata = regs_ff[4];
         snowv_pkg::REG_IV1:  prdata = regs_ff[5];
         default:             prdata = '0;
      endcase
   end

   snowv_control u_control (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_kind  (req_kind),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   snowv_datapath u_datapath (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .key   ({regs_ff[3], regs_ff[2], regs_ff[1], regs_ff[0]}),
      .iv    ({regs_ff[5], regs_ff[4]}),
      .data  ({req_data_high, req_data_low}),
      .text  (text)
   );

   assign rsp_text_low  = text[63:0];
   assign rsp_text_high = text[127:64];

endmodule

// File: sv/snowv_checker.sv
// ----------------------------------------------------------------------------
// snowv_checker
// port-level checks of the keystream block
// ----------------------------------------------------------------------------
module snowv_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        req_kind,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [63:0] rsp_text_low,
   input logic        pready
);

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid)) else $error("ready while result pending");

   a_data_result: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_kind |=> rsp_valid)
      else $error("data word gave no result");

   a_init_silent: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !req_kind |=> !rsp_valid && !req_ready)
      else $error("init word misbehaved");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_text_low))
      else $error("result dropped");

   a_pready: assert property (@(posedge clock) pready) else $error("pready low");

endmodule

bind snow_v_keystream_cipher snowv_checker u_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_ready    (req_ready),
   .req_kind     (req_kind),
   .rsp_valid    (rsp_valid),
   .rsp_ready    (rsp_ready),
   .rsp_text_low (rsp_text_low),
   .pready       (pready)
);
